>>> sv/rkmc_pkg.sv
// Shared types and constants of the rotary knob mode controller.
package rkmc_pkg;

    typedef struct packed {
        logic               button_down;
        logic signed [15:0] count_delta;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  level;
        logic [15:0] effect_index;
        logic [1:0]  press_event;
        logic        rotation_applied;
    } t_out_word;

    // Mode codes.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_BRIGHT = 2'd1;
    localparam logic [1:0] MODE_EFFECT = 2'd2;

    // Press event codes.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_BRIGHT_QUIET = 2'd1;
    localparam logic [1:0] REG_EFFECT_QUIET = 2'd2;

    // Reset values.
    localparam logic [15:0] LONG_PRESS_RST   = 16'd500;
    localparam logic [15:0] BRIGHT_QUIET_RST = 16'd40;
    localparam logic [15:0] EFFECT_QUIET_RST = 16'd150;
    localparam logic [7:0]  LEVEL_RST        = 8'd128;

endpackage

>>> sv/rotary_knob_mode_controller.sv
// Top level of the rotary knob mode controller: button timing, modes and rotation.
//
//  Channel   Direction  Handshake                 Word
//  in        input      i_in_valid / o_in_stall   rkmc_pkg::t_in_word (one tick)
//  out       output     o_out_valid / i_out_stall rkmc_pkg::t_out_word (one result)
//  config    input      APB psel/penable/pwrite   16-bit registers at 0x0, 0x4, 0x8
//
// A tick that does not apply a brightness change is handled in the cycle it is accepted,
// and its result word is loaded into the output register at the same edge.
// A tick that applies a brightness change then passes S_SQ (30*b*b on the one shared
// 17x17 multiplier), S_STEP (the step with its division by 65025), S_MUL (sum*step)
// and S_DONE (clamping, held until the output register is free). A new tick is accepted
// only in the idle state and only when the output register is empty or being taken in
// that cycle. A held output stall therefore stalls the input side as well. Reset is
// synchronous, active low, and restores defaults and all state but r_out, r_prod, r_step.
module rotary_knob_mode_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rkmc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rkmc_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rkmc_pkg::*;

    // Sequencer for the brightness update; one-hot codes.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_STEP = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_long_press;
    logic [15:0] r_bright_quiet;
    logic [15:0] r_effect_quiet;

    // Tick state.
    logic [1:0]         r_mode;
    logic [7:0]         r_level;
    logic [15:0]        r_effect;
    logic [15:0]        r_press_timer;
    logic               r_button_prev;
    logic               r_press_handled;
    logic signed [15:0] r_rot_sum;
    logic               r_rot_pending;
    logic [15:0]        r_quiet_timer;

    // Sequencer data.
    logic [1:0]         r_event;
    logic signed [23:0] r_prod;
    logic [5:0]         r_step;

    // Output register.
    logic               r_out_valid;
    t_out_word          r_out;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    logic in_accept;
    logic out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ------------------------------------------------------------------
    // Configuration port. The user writes only while the block is idle; no check here.
    // ------------------------------------------------------------------
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_LONG_PRESS:   prdata = {16'd0, r_long_press};
            REG_BRIGHT_QUIET: prdata = {16'd0, r_bright_quiet};
            REG_EFFECT_QUIET: prdata = {16'd0, r_effect_quiet};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Tick logic, evaluated on the current state and the offered word.
    // ------------------------------------------------------------------
    logic               tk_edge;
    logic [15:0]        tk_timer;
    logic               tk_handled;
    logic [1:0]         tk_event;
    logic               tk_old_active;
    logic [15:0]        tk_quiet;
    logic signed [16:0] tk_sum_wide;
    logic signed [15:0] tk_sum;
    logic               tk_pending;
    logic [15:0]        tk_qt;
    logic               tk_fire;
    logic [1:0]         tk_mode;
    logic               tk_new_active;
    logic [15:0]        tk_effect;
    logic               tk_applied;
    logic               tk_chain;

    always_comb begin
        tk_edge     = i_in_word.button_down && !r_button_prev;
        tk_timer    = r_press_timer;
        tk_handled  = r_press_handled;
        tk_event    = EV_NONE;
        tk_sum_wide = 17'sd0;
        tk_sum      = r_rot_sum;
        tk_pending  = r_rot_pending;
        tk_qt       = r_quiet_timer;
        tk_fire     = 1'b0;
        tk_mode     = r_mode;
        tk_effect   = r_effect;
        tk_applied  = 1'b0;
        tk_chain    = 1'b0;

        // A press edge restarts the timer; an open press keeps counting.
        if (tk_edge) begin
            tk_timer   = 16'd0;
            tk_handled = 1'b0;
        end else if (!tk_handled) begin
            tk_timer = sat_inc(tk_timer);
        end
        if (!tk_handled) begin
            if (i_in_word.button_down) begin
                if (tk_timer >= r_long_press) begin
                    tk_event   = EV_LONG;
                    tk_handled = 1'b1;
                end
            end else begin
                tk_event   = (tk_timer < r_long_press) ? EV_SHORT : EV_LONG;
                tk_handled = 1'b1;
            end
        end

        // Rotation is gathered under the mode at the start of the tick.
        tk_old_active = (r_mode == MODE_BRIGHT) || (r_mode == MODE_EFFECT);
        tk_quiet      = (r_mode == MODE_BRIGHT) ? r_bright_quiet : r_effect_quiet;
        if (tk_old_active) begin
            if (i_in_word.count_delta != 16'sd0) begin
                tk_sum_wide = {r_rot_sum[15], r_rot_sum}
                            + {i_in_word.count_delta[15], i_in_word.count_delta};
                if (tk_sum_wide > 17'sd32767) begin
                    tk_sum = 16'sh7FFF;
                end else if (tk_sum_wide < -17'sd32768) begin
                    tk_sum = 16'sh8000;
                end else begin
                    tk_sum = tk_sum_wide[15:0];
                end
                tk_pending = 1'b1;
                tk_qt      = 16'd0;
            end else if (tk_pending) begin
                tk_qt = sat_inc(tk_qt);
            end
            if (tk_pending && (tk_qt >= tk_quiet)) begin
                tk_pending = 1'b0;
                tk_fire    = 1'b1;
            end
        end

        // The press moves the mode.
        if (tk_event == EV_SHORT) begin
            tk_mode = (r_mode == MODE_BRIGHT) ? MODE_EFFECT : MODE_BRIGHT;
        end else if (tk_event == EV_LONG) begin
            tk_mode = MODE_OFF;
        end

        // A due rotation is applied in the new mode; entering off drops it.
        tk_new_active = (tk_mode == MODE_BRIGHT) || (tk_mode == MODE_EFFECT);
        if (tk_new_active) begin
            if (tk_fire) begin
                tk_applied = 1'b1;
                if (tk_mode == MODE_BRIGHT) begin
                    // The sum stays in place until the sequencer has used it.
                    tk_chain = 1'b1;
                end else begin
                    tk_effect = r_effect + tk_sum;
                    tk_sum    = 16'sd0;
                end
            end
        end else begin
            tk_sum     = 16'sd0;
            tk_pending = 1'b0;
            tk_qt      = 16'd0;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier and brightness step arithmetic.
    // ------------------------------------------------------------------
    logic [12:0]        lvl30;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;

    assign lvl30 = {r_level, 5'd0} - {4'd0, r_level, 1'b0};

    always_comb begin
        case (r_state)
            S_SQ: begin
                mul_a = signed'({4'd0, lvl30});
                mul_b = signed'({9'd0, r_level});
            end
            S_MUL: begin
                mul_a = signed'({r_rot_sum[15], r_rot_sum});
                mul_b = signed'({11'd0, r_step});
            end
            default: begin
                mul_a = 17'sd0;
                mul_b = 17'sd0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // floor(x / 65025) is either x >> 16 or one more, since x stays below 2^21.
    logic [20:0] sq_x;
    logic [4:0]  q_est;
    logic [5:0]  q_up;
    logic [21:0] q_thr;
    logic [5:0]  step_val;

    assign sq_x     = r_prod[20:0];
    assign q_est    = sq_x[20:16];
    assign q_up     = {1'b0, q_est} + 6'd1;
    assign q_thr    = {q_up, 16'd0} - {7'd0, q_up, 9'd0} + {16'd0, q_up};
    assign step_val = 6'd3 + (({1'b0, sq_x} >= q_thr) ? q_up : {1'b0, q_est});

    logic signed [24:0] lvl_new;
    logic [7:0]         lvl_clamped;

    always_comb begin
        lvl_new = {r_prod[23], r_prod} + signed'({17'd0, r_level});
        if (lvl_new < 25'sd1) begin
            lvl_clamped = 8'd1;
        end else if (lvl_new > 25'sd255) begin
            lvl_clamped = 8'd255;
        end else begin
            lvl_clamped = lvl_new[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------

    // The output register is loaded by an idle tick without a brightness change or by
    // the end of the brightness sequence; loading takes priority over emptying.
    logic out_load;
    assign out_load = ((r_state == S_IDLE) && in_accept && !tk_chain)
                   || ((r_state == S_DONE) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_long_press    <= LONG_PRESS_RST;
            r_bright_quiet  <= BRIGHT_QUIET_RST;
            r_effect_quiet  <= EFFECT_QUIET_RST;
            r_mode          <= MODE_OFF;
            r_level         <= LEVEL_RST;
            r_effect        <= 16'd0;
            r_press_timer   <= 16'd0;
            r_button_prev   <= 1'b0;
            r_press_handled <= 1'b1;
            r_rot_sum       <= 16'sd0;
            r_rot_pending   <= 1'b0;
            r_quiet_timer   <= 16'd0;
            r_event         <= EV_NONE;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[3:2])
                    REG_LONG_PRESS:   r_long_press   <= pwdata[15:0];
                    REG_BRIGHT_QUIET: r_bright_quiet <= pwdata[15:0];
                    REG_EFFECT_QUIET: r_effect_quiet <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_press_timer   <= tk_timer;
                        r_press_handled <= tk_handled;
                        r_button_prev   <= i_in_word.button_down;
                        r_mode          <= tk_mode;
                        r_effect        <= tk_effect;
                        r_rot_sum       <= tk_sum;
                        r_rot_pending   <= tk_pending;
                        r_quiet_timer   <= tk_qt;
                        r_event         <= tk_event;
                        if (tk_chain) begin
                            r_state <= S_SQ;
                        end else begin
                            r_out       <= '{mode: tk_mode, level: r_level,
                                             effect_index: tk_effect,
                                             press_event: tk_event,
                                             rotation_applied: tk_applied};
                        end
                    end
                end
                S_SQ: begin
                    r_prod  <= mul_p[23:0];
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_step  <= step_val;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul_p[23:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_level     <= lvl_clamped;
                        r_rot_sum   <= 16'sd0;
                        r_out       <= '{mode: r_mode, level: lvl_clamped,
                                         effect_index: r_effect,
                                         press_event: r_event,
                                         rotation_applied: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.level != 8'd0))
        else $error("level word out of range");

    a_applied_not_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.rotation_applied) |-> (o_out_word.mode != MODE_OFF))
        else $error("rotation applied while off");

    a_pending_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rot_pending |-> ((r_mode == MODE_BRIGHT) || (r_mode == MODE_EFFECT)))
        else $error("rotation pending while off");

    a_chain_in_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> ($past(r_state == S_IDLE) && (r_mode == MODE_BRIGHT)))
        else $error("brightness sequence started outside brightness mode");

endmodule
